// ===== rtl/btxc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btxc_pkg: shared types and constants
// Command and status codes, defaults and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package btxc_pkg;

  localparam int unsigned KeyBitsDef   = 31;
  localparam int unsigned NodeCountDef = 65536;
  localparam int unsigned CountBitsDef = 20;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LimitW  = 32;
  localparam int unsigned OutCntW = 20;

  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdDelete = 2'd1;
  localparam logic [CmdW-1:0] CmdQuery  = 2'd2;
  // unassigned code: changes nothing, answers ok with a zero count
  localparam logic [CmdW-1:0] CmdSpare  = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request, root to walk pointer
    logic sib_add;   // add sibling count, advance level
    logic clr_step;  // write zero to clear address, advance
    logic rd;        // issue memory read at walk node
    logic ins_step;  // insert level update
    logic del_chk;   // delete check level
    logic del_step;  // delete level update
    logic qry_step;  // query level, read sibling
    logic out_load;  // capture count into output register
    logic fin_ins;   // final leaf increment
    logic fin_del;   // final leaf decrement
    logic fin_qry;   // final query add
    logic restart;   // go back to root for second pass
  } btxc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic last_level;
    logic null_node;
    logic full;
    logic zero_limit;
    logic absent;
  } btxc_stat_t;

endpackage

// ===== rtl/btxc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btxc_datapath: trie memories and walk registers
// Holds the node memory, the walk pointer, the level counter and the sums.
// ----------------------------------------------------------------------------
module btxc_datapath #(
  parameter int unsigned KeyBits   = btxc_pkg::KeyBitsDef,
  parameter int unsigned NodeCount = btxc_pkg::NodeCountDef,
  parameter int unsigned CountBits = btxc_pkg::CountBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  btxc_pkg::btxc_cmd_t            cmd_i,
  output btxc_pkg::btxc_stat_t           stat_o,
  input  logic [KeyBits-1:0]             key_i,
  input  logic [btxc_pkg::LimitW-1:0]    limit_i,
  output logic [btxc_pkg::OutCntW-1:0]   match_count_o
);
  localparam int unsigned NodeW = $clog2(NodeCount);
  localparam int unsigned FreeW = NodeW + 1;
  localparam int unsigned LvlW  = (KeyBits > 1) ? $clog2(KeyBits) : 1;
  localparam int unsigned PreW  = KeyBits + 1;
  localparam int unsigned CmpW  = (PreW > btxc_pkg::LimitW) ? PreW : btxc_pkg::LimitW;
  localparam logic [CountBits-1:0] CountMax = '1;

  // node word: zero link, one link, key count
  localparam int unsigned WordW = 2 * NodeW + CountBits;
  logic [WordW-1:0] mem [NodeCount];
  logic [WordW-1:0] rdata_q;

  logic [NodeW-1:0]     clr_addr_q, clr_addr_d;
  logic                 clr_done_q;
  logic [NodeW-1:0]     node_q, node_d;
  logic [LvlW-1:0]      lvl_q, lvl_d;
  logic [KeyBits-1:0]   key_q;
  logic [CmpW-1:0]      limit_q;
  logic [CmpW-1:0]      prefix_q, prefix_d;
  logic [CountBits-1:0] sum_q, sum_d;
  logic [CountBits-1:0] out_cnt_q;
  logic [FreeW-1:0]     free_q, free_d;
  logic [CountBits-1:0] total_q, total_d;
  logic [NodeW-1:0]     sib_q, sib_d;

  logic                 we;
  logic [NodeW-1:0]     waddr;
  logic [WordW-1:0]     wdata;
  logic [NodeW-1:0]     raddr;

  logic [NodeW-1:0]     rd_zero, rd_one;
  logic [CountBits-1:0] rd_cnt;
  logic                 bit_k;
  logic [NodeW-1:0]     nx_b, nx_nb;
  logic [CmpW-1:0]      step;

  assign rd_zero = rdata_q[WordW-1 -: NodeW];
  assign rd_one  = rdata_q[CountBits +: NodeW];
  assign rd_cnt  = rdata_q[CountBits-1:0];
  assign bit_k   = key_q[lvl_q];
  assign nx_b    = bit_k ? rd_one : rd_zero;
  assign nx_nb   = bit_k ? rd_zero : rd_one;
  assign step    = CmpW'(1) << lvl_q;

  // Memory port: one write, one registered read
  assign raddr = cmd_i.qry_step ? sib_d : node_q;
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  // Walk control
  always_comb begin
    we         = 1'b0;
    waddr      = node_q;
    wdata      = rdata_q;
    clr_addr_d = clr_addr_q;
    node_d     = node_q;
    lvl_d      = lvl_q;
    prefix_d   = prefix_q;
    sum_d      = sum_q;
    free_d     = free_q;
    total_d    = total_q;
    sib_d      = sib_q;
    if (cmd_i.clr_step) begin
      we         = 1'b1;
      waddr      = clr_addr_q;
      wdata      = '0;
      clr_addr_d = clr_addr_q + 1'b1;
    end
    if (cmd_i.load) begin
      node_d   = NodeW'(1);
      lvl_d    = LvlW'(KeyBits - 1);
      prefix_d = '0;
      sum_d    = '0;
    end
    if (cmd_i.restart) begin
      node_d = NodeW'(1);
      lvl_d  = LvlW'(KeyBits - 1);
    end
    if (cmd_i.ins_step) begin
      we = 1'b1;
      wdata[CountBits-1:0] = rd_cnt + 1'b1;
      if (nx_b == '0) begin
        if (bit_k) begin
          wdata[CountBits +: NodeW] = free_q[NodeW-1:0];
        end else begin
          wdata[WordW-1 -: NodeW] = free_q[NodeW-1:0];
        end
        node_d = free_q[NodeW-1:0];
        free_d = free_q + 1'b1;
      end else begin
        node_d = nx_b;
      end
      lvl_d = lvl_q - 1'b1;
    end
    if (cmd_i.del_chk) begin
      node_d = nx_b;
      lvl_d  = lvl_q - 1'b1;
    end
    if (cmd_i.del_step) begin
      we = 1'b1;
      wdata[CountBits-1:0] = rd_cnt - 1'b1;
      node_d = nx_b;
      lvl_d  = lvl_q - 1'b1;
    end
    if (cmd_i.qry_step) begin
      // take the matching branch whole when the bound allows, follow the other
      if (prefix_q + step < limit_q) begin
        prefix_d = prefix_q + step;
        sib_d    = nx_b;
        node_d   = nx_nb;
      end else begin
        sib_d  = '0;
        node_d = nx_b;
      end
    end
    if (cmd_i.fin_ins) begin
      we = 1'b1;
      wdata[CountBits-1:0] = rd_cnt + 1'b1;
      total_d = total_q + 1'b1;
    end
    if (cmd_i.fin_del) begin
      we = 1'b1;
      wdata[CountBits-1:0] = rd_cnt - 1'b1;
      total_d = total_q - 1'b1;
    end
    if (cmd_i.fin_qry) begin
      sum_d = sum_q + ((node_q == '0) ? '0 : rd_cnt);
    end
    if (cmd_i.sib_add) begin
      // sibling count read done: add it and drop to the next level
      sum_d = sum_q + ((sib_q == '0) ? '0 : rd_cnt);
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_done_q <= 1'b0;
      free_q     <= FreeW'(2);
      total_q    <= '0;
      node_q     <= '0;
      lvl_q      <= '0;
      prefix_q   <= '0;
      sum_q      <= '0;
      sib_q      <= '0;
      out_cnt_q  <= '0;
    end else begin
      clr_addr_q <= clr_addr_d;
      if (cmd_i.clr_step && clr_addr_q == NodeW'(NodeCount - 1)) begin
        clr_done_q <= 1'b1;
      end
      free_q   <= free_d;
      total_q  <= total_d;
      node_q   <= node_d;
      lvl_q    <= lvl_d;
      prefix_q <= prefix_d;
      sum_q    <= sum_d;
      sib_q    <= sib_d;
      if (cmd_i.out_load) begin
        out_cnt_q <= sum_q;
      end
    end
  end

  // Capture request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= key_i;
      limit_q <= CmpW'(limit_i);
    end
  end

  assign stat_o.clr_done   = clr_done_q;
  assign stat_o.last_level = (lvl_q == '0);
  assign stat_o.null_node  = (node_q == '0);
  assign stat_o.full       = (FreeW'(NodeCount) - free_q < FreeW'(KeyBits))
                             || (total_q == CountMax);
  assign stat_o.zero_limit = (limit_q == '0);
  assign stat_o.absent     = (node_q == '0) || (rd_cnt == '0);
  assign match_count_o     = btxc_pkg::OutCntW'(out_cnt_q);

  // Assertions
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FreeW'(NodeCount)) else $error("free pointer beyond memory");
  a_clr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_done_q |=> clr_done_q) else $error("clear done dropped");
  a_no_clr_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !cmd_i.ins_step && !cmd_i.del_step)
    else $error("clear overlaps write");
endmodule

// ===== rtl/btxc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btxc_ctrl: command sequencer
// Clears memory after reset, then walks each request level by level.
// ----------------------------------------------------------------------------
module btxc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [btxc_pkg::CmdW-1:0]     command_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [btxc_pkg::StatusW-1:0]  status_o,
  output btxc_pkg::btxc_cmd_t           cmd_o,
  input  btxc_pkg::btxc_stat_t          stat_i
);
  typedef enum logic [3:0] {
    StClear, StIdle, StInsRd, StInsUpd, StDelRd, StDelChk, StDelRd2,
    StDelUpd, StQryRd, StQryUpd, StQrySib, StFinRd, StFin, StOut
  } state_e;

  state_e state_q, state_d;
  logic [btxc_pkg::CmdW-1:0]    op_q, op_d;
  logic [btxc_pkg::StatusW-1:0] st_q, st_d;
  logic [btxc_pkg::StatusW-1:0] out_st_q, out_st_d;
  logic                         cnt_q, cnt_d;
  logic                         out_v_q, out_v_d;
  btxc_pkg::btxc_cmd_t          c;

  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = out_v_q;
  assign status_o  = out_st_q;
  assign cmd_o     = c;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    st_d     = st_q;
    out_st_d = out_st_q;
    cnt_d    = cnt_q;
    out_v_d  = out_v_q;
    c        = '0;
    if (out_v_q && m_ready_i) begin
      out_v_d = 1'b0;
    end
    case (state_q)
      StClear: begin
        c.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (s_valid_i) begin
          c.load = 1'b1;
          op_d   = command_i;
          st_d   = btxc_pkg::StOk;
          cnt_d  = 1'b0;
          case (command_i)
            btxc_pkg::CmdInsert: begin
              // refuse up front when the free nodes or the key total run out
              if (stat_i.full) begin
                st_d    = btxc_pkg::StFull;
                state_d = StOut;
              end else begin
                state_d = StInsRd;
              end
            end
            btxc_pkg::CmdDelete: state_d = StDelRd;
            btxc_pkg::CmdQuery:  state_d = StQryRd;
            default:             state_d = StOut;
          endcase
        end
      end
      StInsRd: begin
        c.rd = 1'b1;
        state_d = StInsUpd;
      end
      StInsUpd: begin
        c.ins_step = 1'b1;
        state_d = stat_i.last_level ? StFinRd : StInsRd;
      end
      StDelRd: begin
        if (stat_i.null_node) begin
          state_d = StFinRd;
        end else begin
          c.rd = 1'b1;
          state_d = StDelChk;
        end
      end
      StDelChk: begin
        c.del_chk = 1'b1;
        state_d = stat_i.last_level ? StFinRd : StDelRd;
      end
      StDelRd2: begin
        c.rd = 1'b1;
        state_d = StDelUpd;
      end
      StDelUpd: begin
        c.del_step = 1'b1;
        state_d = stat_i.last_level ? StFinRd : StDelRd2;
      end
      StQryRd: begin
        if (stat_i.zero_limit || stat_i.null_node) begin
          state_d = StOut;
        end else begin
          c.rd = 1'b1;
          state_d = StQryUpd;
        end
      end
      StQryUpd: begin
        c.qry_step = 1'b1;
        c.rd       = 1'b1;
        state_d    = StQrySib;
      end
      StQrySib: begin
        c.sib_add = 1'b1;
        state_d = stat_i.last_level ? StFinRd : StQryRd;
      end
      StFinRd: begin
        c.rd = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        case (op_q)
          btxc_pkg::CmdInsert: c.fin_ins = 1'b1;
          btxc_pkg::CmdDelete: begin
            if (st_q == btxc_pkg::StOk && cnt_q) begin
              c.fin_del = 1'b1;
            end
          end
          btxc_pkg::CmdQuery: c.fin_qry = 1'b1;
          default: ;
        endcase
        if (op_q == btxc_pkg::CmdDelete && !cnt_q) begin
          // end of check pass
          if (stat_i.absent) begin
            st_d = btxc_pkg::StNotFound;
            state_d = StOut;
          end else begin
            cnt_d = 1'b1;
            c.restart = 1'b1;
            state_d = StDelRd2;
          end
        end else begin
          if (op_q == btxc_pkg::CmdDelete) cnt_d = 1'b0;
          state_d = StOut;
        end
      end
      StOut: begin
        // hand over to the output register once it is free
        if (!out_v_q || m_ready_i) begin
          out_v_d    = 1'b1;
          out_st_d   = st_q;
          c.out_load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      op_q     <= btxc_pkg::CmdInsert;
      st_q     <= btxc_pkg::StOk;
      out_st_q <= btxc_pkg::StOk;
      cnt_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      st_q     <= st_d;
      out_st_q <= out_st_d;
      cnt_q    <= cnt_d;
      out_v_q  <= out_v_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_ready_i |=> out_v_q) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_ready_o) else $error("ready while busy");
  a_cnt_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == btxc_pkg::StFull) |-> (op_q == btxc_pkg::CmdInsert))
    else $error("full on non-insert");
endmodule

// ===== rtl/binary_trie_xor_less_count_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_xor_less_count_unit: trie of keys with xor-bound counting
// After reset the node memory is swept clear, one node a cycle, before the first
// request is taken. Each request then walks the KEY_BITS trie levels through one
// node memory with one write and one read port, a read state then an update
// state a level (a query also reads and adds the sibling count): insert walks
// once, delete makes a check pass then an update pass, a query walks once.
// One request is in flight at a time; the result waits in an output register.
// ----------------------------------------------------------------------------
module binary_trie_xor_less_count_unit #(
  parameter int unsigned KeyBits   = btxc_pkg::KeyBitsDef,
  parameter int unsigned NodeCount = btxc_pkg::NodeCountDef,
  parameter int unsigned CountBits = btxc_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] command, [32:2] key, [64:33] limit, zero fill to 72 bits
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [21:2] match_count, zero fill to 24 bits
  output logic [23:0] m_axis_tdata_o
);
  btxc_pkg::btxc_cmd_t  cmd;
  btxc_pkg::btxc_stat_t stat;
  logic [btxc_pkg::StatusW-1:0] status;
  logic [btxc_pkg::OutCntW-1:0] cnt;

  btxc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .command_i (s_axis_tdata_i[1:0]),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_o  (status),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  btxc_datapath #(.KeyBits(KeyBits), .NodeCount(NodeCount), .CountBits(CountBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .key_i         (KeyBits'(s_axis_tdata_i[32:2])),
    .limit_i       (s_axis_tdata_i[64:33]),
    .match_count_o (cnt)
  );

  assign m_axis_tdata_o = {2'b00, cnt, status};
endmodule

// ===== tb/tb_binary_trie_xor_less_count_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_trie_xor_less_count_unit: self-checking bench for the trie unit
// Drives insert, delete and xor-bound count requests over the input stream,
// predicts each response with a behavioural trie kept in associative arrays
// and compares status and count of every response in arrival order. Both
// stream sides idle in random bursts; one long output stall fills the unit.
// ----------------------------------------------------------------------------
module tb_binary_trie_xor_less_count_unit;

  localparam int unsigned KeyW      = 31;
  localparam int unsigned NodeTotal = 65536;
  localparam logic [19:0] CountMax  = 20'hFFFFF;
  localparam int unsigned RandItems = 430;
  localparam int unsigned StallLen  = 3000;
  localparam int unsigned IdleLimit = 200000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [30:0] key;
    logic [31:0] limit;
  } trie_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] count;
  } trie_rsp_t;

  // Directed row: request, typed-in response where obvious
  typedef struct {
    trie_req_t req;
    logic      fixed;
    trie_rsp_t rsp;
  } trie_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  // Shadow trie
  int unsigned zero_link[int unsigned];
  int unsigned one_link[int unsigned];
  logic [19:0] keys_below[int unsigned];
  int unsigned free_node;
  logic [19:0] key_total;

  trie_rsp_t   rsp_queue[$];
  logic        rsp_fixed[$];
  trie_rsp_t   rsp_typed[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned out_gap = 0;
  bit          quiet = 1'b0;
  bit          hold_off = 1'b0;
  logic [30:0] used_keys[$];

  always #1 clk_i = ~clk_i;

  binary_trie_xor_less_count_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  function automatic int unsigned child_of(int unsigned node, bit b);
    if (b) return one_link.exists(node) ? one_link[node] : 0;
    return zero_link.exists(node) ? zero_link[node] : 0;
  endfunction

  function automatic logic [19:0] keys_of(int unsigned node);
    if (node == 0 || !keys_below.exists(node)) return '0;
    return keys_below[node];
  endfunction

  // Update the shadow trie and return the expected response
  function automatic trie_rsp_t trie_apply(trie_req_t r);
    trie_rsp_t   o;
    int unsigned n;
    int unsigned nx;
    longint unsigned prefix;
    longint unsigned stride;
    logic [19:0] sum;
    bit          b;
    o = '0;
    case (r.cmd)
      btxc_pkg::CmdInsert: begin
        if (NodeTotal - free_node < KeyW || key_total >= CountMax) begin
          o.status = btxc_pkg::StFull;
        end else begin
          n = 1;
          for (int i = KeyW - 1; i >= 0; i--) begin
            b = r.key[i];
            keys_below[n] = keys_of(n) + 20'd1;
            nx = child_of(n, b);
            if (nx == 0) begin
              nx = free_node++;
              if (b) one_link[n] = nx;
              else zero_link[n] = nx;
            end
            n = nx;
          end
          keys_below[n] = keys_of(n) + 20'd1;
          key_total++;
        end
      end
      btxc_pkg::CmdDelete: begin
        n = 1;
        for (int i = KeyW - 1; i >= 0 && n != 0; i--) n = child_of(n, r.key[i]);
        if (keys_of(n) == 0) begin
          o.status = btxc_pkg::StNotFound;
        end else begin
          n = 1;
          for (int i = KeyW - 1; i >= 0; i--) begin
            keys_below[n] = keys_of(n) - 20'd1;
            n = child_of(n, r.key[i]);
          end
          keys_below[n] = keys_of(n) - 20'd1;
          key_total--;
        end
      end
      btxc_pkg::CmdQuery: begin
        if (r.limit != 0) begin
          n = 1;
          prefix = 0;
          sum = '0;
          for (int i = KeyW - 1; i >= 0 && n != 0; i--) begin
            b = r.key[i];
            stride = 64'd1 << i;
            if (prefix + stride < r.limit) begin
              prefix += stride;
              sum += keys_of(child_of(n, b));
              n = child_of(n, !b);
            end else begin
              n = child_of(n, b);
            end
          end
          o.count = sum + keys_of(n);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_req(trie_req_t r, logic fixed, trie_rsp_t typed, bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, r.limit, r.key, r.cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    rsp_queue = {rsp_queue, trie_apply(r)};
    rsp_fixed = {rsp_fixed, fixed};
    rsp_typed = {rsp_typed, typed};
  endtask

  function automatic logic [30:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1, 2: if (used_keys.size() != 0)
        return used_keys[$urandom_range(0, used_keys.size() - 1)];
      3: return 31'($urandom_range(0, 15));
      default: ;
    endcase
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h8000_0000 + 32'($urandom_range(0, 1)) * 32'h7FFF_FFFF;
      2: return 32'($urandom_range(1, 64));
      default: return $urandom;
    endcase
  endfunction

  // Output side: random idle bursts, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_axis_tready_i <= 1'b0;
    end else if (quiet) begin
      m_axis_tready_i <= 1'b1;
    end else if (out_gap != 0) begin
      m_axis_tready_i <= 1'b0;
      out_gap         <= out_gap - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready_i <= 1'b0;
      out_gap         <= $urandom_range(0, 13);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compare each response against the oldest expectation
  always @(posedge clk_i) begin
    trie_rsp_t got;
    trie_rsp_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = m_axis_tdata_o[1:0];
      got.count  = m_axis_tdata_o[21:2];
      if (rsp_queue.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        err_cnt++;
      end else begin
        want = rsp_queue.pop_front();
        if (rsp_fixed.pop_front()) begin
          if (rsp_typed[0] !== want) begin
            $display("%0t: table row disagrees: expected %h model %h", $time,
                     rsp_typed[0], want);
            err_cnt++;
          end
        end
        void'(rsp_typed.pop_front());
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          err_cnt++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; covers the clearing sweep
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_binary_trie_xor_less_count_unit NOT OK");
      $finish;
    end
  end

  initial begin
    trie_row_t   rows[$];
    trie_req_t   r;
    int unsigned sel;
    free_node = 2;
    key_total = '0;

    // Directed table
    rows = '{
      '{'{btxc_pkg::CmdQuery,  31'h0,        32'hFFFF_FFFF}, 1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdDelete, 31'h0,        32'h0},         1'b1,
        '{btxc_pkg::StNotFound, 20'd0}},
      '{'{btxc_pkg::CmdInsert, 31'h0,        32'h0},         1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdInsert, 31'h7FFFFFFF, 32'hFFFF_FFFF}, 1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdInsert, 31'h7FFFFFFF, 32'h0},         1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdQuery,  31'h1234,     32'h0},         1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdQuery,  31'h0,        32'h8000_0000}, 1'b1,
        '{btxc_pkg::StOk, 20'd3}},
      '{'{btxc_pkg::CmdQuery,  31'h5555,     32'hFFFF_FFFF}, 1'b1,
        '{btxc_pkg::StOk, 20'd3}},
      '{'{btxc_pkg::CmdQuery,  31'h0,        32'h1},         1'b1,
        '{btxc_pkg::StOk, 20'd1}},
      '{'{btxc_pkg::CmdQuery,  31'h7FFFFFFF, 32'h1},         1'b1,
        '{btxc_pkg::StOk, 20'd2}},
      '{'{btxc_pkg::CmdQuery,  31'h2AAAAAAA, 32'h7FFF_FFFF}, 1'b0, '0},
      '{'{btxc_pkg::CmdQuery,  31'h55555555, 32'h4000_0000}, 1'b0, '0},
      '{'{btxc_pkg::CmdSpare,  31'h7FFFFFFF, 32'hFFFF_FFFF}, 1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdDelete, 31'h7FFFFFFF, 32'h0},         1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdDelete, 31'h1,        32'h0},         1'b1,
        '{btxc_pkg::StNotFound, 20'd0}},
      '{'{btxc_pkg::CmdQuery,  31'h7FFFFFFF, 32'h1},         1'b1,
        '{btxc_pkg::StOk, 20'd1}},
      '{'{btxc_pkg::CmdDelete, 31'h7FFFFFFF, 32'h0},         1'b1,
        '{btxc_pkg::StOk, 20'd0}},
      '{'{btxc_pkg::CmdDelete, 31'h7FFFFFFF, 32'h0},         1'b1,
        '{btxc_pkg::StNotFound, 20'd0}},
      '{'{btxc_pkg::CmdInsert, 31'h2AAAAAAA, 32'h0},         1'b0, '0},
      '{'{btxc_pkg::CmdInsert, 31'h55555555, 32'h0},         1'b0, '0},
      '{'{btxc_pkg::CmdQuery,  31'h2AAAAAAA, 32'h5000_0000}, 1'b0, '0}
    };
    used_keys = '{31'h0, 31'h7FFFFFFF, 31'h2AAAAAAA, 31'h55555555};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_req(rows[i].req, rows[i].fixed, rows[i].rsp, 1'b1);

    // Random part; a long output stall partway through
    for (int i = 0; i < RandItems; i++) begin
      if (i == 60) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (StallLen) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == RandItems - 60) quiet = 1'b1;
      sel = $urandom_range(0, 9);
      r.cmd   = sel < 4 ? btxc_pkg::CmdInsert : sel < 6 ? btxc_pkg::CmdDelete :
                sel < 9 ? btxc_pkg::CmdQuery : btxc_pkg::CmdSpare;
      r.key   = pick_key();
      r.limit = pick_limit();
      if (r.cmd == btxc_pkg::CmdInsert && used_keys.size() < 64) begin
        used_keys = {used_keys, r.key};
      end
      send_req(r, 1'b0, '0, 1'b1);
    end
    s_axis_tvalid_i <= 1'b0;

    while (rsp_queue.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_binary_trie_xor_less_count_unit OK");
    end else begin
      $display("tb_binary_trie_xor_less_count_unit NOT OK");
    end
    $finish;
  end

endmodule
